/* rtl/lsd_pkg.sv */
// Shared types, constants and helpers for the lottery draw block.
package lsd_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int TICKET_W = 16;
   localparam int SLOT_W = 6;
   localparam int OUT_W = 22;
   localparam int RAND_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [OUT_W-1:0] OUT_MAX = '1;
   localparam logic [RAND_W-1:0] LCG_MUL = 32'd1664525;
   localparam logic [RAND_W-1:0] LCG_ADD = 32'd1013904223;
   localparam logic [RAND_W-1:0] RAND_RESET = 32'd1;

   localparam logic [TICKET_W-1:0] MIN_RESET = 16'd1;
   localparam logic [TICKET_W-1:0] MAX_RESET = 16'd100;
   localparam logic [TICKET_W-1:0] DEFAULT_RESET = 16'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT = 2'd2;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SUM,
      ST_LCG,
      ST_LOAD,
      ST_MOD,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic op;
      logic [SLOT_W-1:0] slot;
      logic signed [TICKET_W-1:0] ticket_request;
      logic runnable;
   } req_type;

   typedef struct packed {
      logic found;
      logic [SLOT_W-1:0] winner_slot;
      logic [OUT_W-1:0] draw_value;
      logic [OUT_W-1:0] total_tickets;
      logic [TICKET_W-1:0] stored_tickets;
   } rsp_type;

   function automatic logic [OUT_W-1:0] sat_out(input logic [RAND_W-1:0] v);
      return (v > RAND_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
   endfunction

endpackage

/* rtl/lsd_ticket_ram.sv */
// Ticket count memory: one write port, one registered read port.
module lsd_ticket_ram #(
   parameter int DEPTH = lsd_pkg::SLOTS_DEFAULT,
   parameter int DATA_W = lsd_pkg::TICKET_W,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] ticket_mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ticket_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= ticket_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lsd_mod_unit.sv */
// Serial restoring remainder unit, one dividend bit per cycle.
module lsd_mod_unit #(
   parameter int DIV_W = lsd_pkg::OUT_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lsd_pkg::RAND_W-1:0]  dividend,
   input  logic [DIV_W-1:0]            divisor,
   output logic                        done,
   output logic [DIV_W-1:0]            remainder
);
   import lsd_pkg::*;

   localparam int STEP_W = $clog2(RAND_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RAND_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [RAND_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;

   logic [DIV_W:0]    shift;
   logic [DIV_W+1:0]  diff;
   logic [DIV_W-1:0]  rem_step;

   always_comb begin
      shift = {rem_ff, dvd_ff[RAND_W-1]};
      diff = {1'b0, shift} - {2'b00, dsr_ff};
      rem_step = diff[DIV_W+1] ? shift[DIV_W-1:0] : diff[DIV_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      dsr_in = dsr_ff;
      rem_in = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
      end else if (busy_ff) begin
         rem_in = rem_step;
         dvd_in = {dvd_ff[RAND_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign remainder = rem_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff && dsr_ff != '0 |-> rem_ff < dsr_ff)
      else $error("remainder not below divisor");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("done while busy");
   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && cnt_ff == LAST_STEP |=> done_ff)
      else $error("no done after last step");
`endif

endmodule

/* rtl/lottery_scheduler_draw_core.sv */
// Lottery draw core: slot ticket table, runnable total, LCG draw and winner walk.
// Update item: slot write, then one pass over the table to sum.
// Draw item: sum pass, LCG multiply and load, serial remainder, winner walk that stops at the
// first hit; an empty draw ends after the sum pass.
// One item at a time; next item taken in the cycle after the result register loads.
// Synchronous reset: tickets read as zero via cleared runnable flags, random state one.
module lottery_scheduler_draw_core #(
   parameter int SLOTS = lsd_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lsd_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lsd_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [lsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lsd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lsd_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int TOTAL_W = TICKET_W + IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOTS);

   state_type state_ff, state_in;

   logic [TICKET_W-1:0] min_ff, min_in;
   logic [TICKET_W-1:0] max_ff, max_in;
   logic [TICKET_W-1:0] dflt_ff, dflt_in;

   req_type             item_ff, item_in;
   logic [SLOTS-1:0]    flags_ff, flags_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                pipe_vld_ff, pipe_vld_in;
   logic                pipe_flag_ff, pipe_flag_in;
   logic [IDX_W-1:0]    pipe_idx_ff, pipe_idx_in;
   logic [TOTAL_W-1:0]  scan_ff, scan_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    win_ff, win_in;
   logic [RAND_W-1:0]   prod_ff, prod_in;
   logic [RAND_W-1:0]   rand_ff, rand_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                ram_we, mod_start, scan_run, is_sum;
   logic                accept, is_draw, slot_ok, rd_en, take, hit, last, out_free;
   logic [IDX_W-1:0]    rd_addr;
   logic [TICKET_W-1:0] rd_ticket;
   logic [TICKET_W-1:0] clamp_val;
   logic [TOTAL_W-1:0]  tkt_ext, alu_out, sum_next;
   logic                mod_done;
   logic [TOTAL_W-1:0]  mod_rem;

   lsd_ticket_ram #(
      .DEPTH  (SLOTS),
      .DATA_W (TICKET_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (IDX_W'(item_ff.slot)),
      .wr_data (clamp_val),
      .rd_addr (rd_addr),
      .rd_data (rd_ticket)
   );

   lsd_mod_unit #(
      .DIV_W (TOTAL_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (prod_ff + LCG_ADD),
      .divisor   (total_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // clamp, in the order zero, below min, above max
   always_comb begin
      if (item_ff.ticket_request == '0) begin
         clamp_val = dflt_ff;
      end else if (item_ff.ticket_request < $signed({1'b0, min_ff})) begin
         clamp_val = min_ff;
      end else if (item_ff.ticket_request > $signed({1'b0, max_ff})) begin
         clamp_val = max_ff;
      end else begin
         clamp_val = item_ff.ticket_request;
      end
   end

   always_comb begin
      accept = req_valid && req_ready;
      is_draw = item_ff.op == OP_DRAW;
      slot_ok = 32'(item_ff.slot) < 32'(SLOTS);
      rd_en = cnt_ff < CNT_END;
      rd_addr = cnt_ff[IDX_W-1:0];
      take = pipe_vld_ff && pipe_flag_ff;
      last = pipe_vld_ff && pipe_idx_ff == LAST_IDX;
      tkt_ext = TOTAL_W'(rd_ticket);
      alu_out = is_sum ? scan_ff + tkt_ext : scan_ff - tkt_ext;
      sum_next = take ? alu_out : scan_ff;
      hit = (state_ff == ST_WALK) && take && (scan_ff < tkt_ext);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.op == OP_DRAW) ? ST_SUM : ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_SUM;
         ST_SUM: begin
            if (last) begin
               state_in = (is_draw && sum_next != '0) ? ST_LCG : ST_DONE;
            end
         end
         ST_LCG: state_in = ST_LOAD;
         ST_LOAD: state_in = ST_MOD;
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (hit || last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ram_we = 1'b0;
      mod_start = 1'b0;
      scan_run = 1'b0;
      is_sum = 1'b0;
      unique case (state_ff) inside
         ST_IDLE: req_ready = 1'b1;
         ST_WRITE: ram_we = slot_ok;
         ST_SUM: begin
            scan_run = 1'b1;
            is_sum = 1'b1;
         end
         ST_LOAD: mod_start = 1'b1;
         ST_WALK: scan_run = 1'b1;
         ST_LCG, ST_MOD, ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      dflt_in = dflt_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN: min_in = csr_wdata;
            CSR_MAX: max_in = csr_wdata;
            CSR_DEFAULT: dflt_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      item_in = accept ? req_data : item_ff;
      flags_in = flags_ff;
      if (ram_we) begin
         flags_in[IDX_W'(item_ff.slot)] = item_ff.runnable;
      end

      cnt_in = '0;
      pipe_vld_in = 1'b0;
      if (scan_run) begin
         cnt_in = rd_en ? cnt_ff + 1'b1 : cnt_ff;
         pipe_vld_in = rd_en;
      end
      pipe_idx_in = rd_addr;
      pipe_flag_in = flags_ff[rd_addr];

      scan_in = scan_ff;
      total_in = total_ff;
      found_in = found_ff;
      win_in = win_ff;
      prod_in = prod_ff;
      rand_in = rand_ff;
      case (state_ff) inside
         ST_IDLE, ST_WRITE: begin
            scan_in = '0;
            total_in = '0;
            found_in = 1'b0;
            win_in = '0;
         end
         ST_SUM: begin
            scan_in = sum_next;
            if (last) begin
               total_in = sum_next;
            end
         end
         ST_LCG: prod_in = rand_ff * LCG_MUL;
         ST_MOD: begin
            if (mod_done) begin
               scan_in = mod_rem;
               rand_in = RAND_W'(mod_rem);
            end
         end
         ST_WALK: begin
            if (hit) begin
               found_in = 1'b1;
               win_in = pipe_idx_ff;
            end else if (take) begin
               scan_in = alu_out;
            end
         end
         default: begin
         end
      endcase

      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in.found = found_ff;
         rsp_in.winner_slot = SLOT_W'(win_ff);
         rsp_in.total_tickets = sat_out(RAND_W'(total_ff));
         if (is_draw) begin
            rsp_in.draw_value = (total_ff != '0) ? sat_out(rand_ff) : '0;
            rsp_in.stored_tickets = '0;
         end else begin
            rsp_in.draw_value = '0;
            rsp_in.stored_tickets = clamp_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         min_ff <= MIN_RESET;
         max_ff <= MAX_RESET;
         dflt_ff <= DEFAULT_RESET;
         flags_ff <= '0;
         cnt_ff <= '0;
         pipe_vld_ff <= 1'b0;
         rand_ff <= RAND_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         min_ff <= min_in;
         max_ff <= max_in;
         dflt_ff <= dflt_in;
         flags_ff <= flags_in;
         cnt_ff <= cnt_in;
         pipe_vld_ff <= pipe_vld_in;
         rand_ff <= rand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      pipe_idx_ff <= pipe_idx_in;
      pipe_flag_ff <= pipe_flag_in;
      scan_ff <= scan_in;
      total_ff <= total_in;
      found_ff <= found_in;
      win_ff <= win_in;
      prod_ff <= prod_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      hit |-> scan_ff < total_ff)
      else $error("walk remainder not below total");
   a_found_has_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> rsp_ff.total_tickets != '0)
      else $error("winner reported with empty total");
   a_rand_below_total: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOD && mod_done |=> rand_ff < RAND_W'(total_ff))
      else $error("random state not reduced below total");
`endif

endmodule

/* tb/lottery_draw_checker.sv */
`timescale 1ns / 100ps
// Lottery draw checker: tracks the slot table, predicts each result and compares it.
module lottery_draw_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  lsd_pkg::req_type                    req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  lsd_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [lsd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lsd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                  error_count,
   output int                                  pending_count,
   output int                                  win_count
);
   import lsd_pkg::*;

   logic [TICKET_W-1:0] slot_tickets [SLOTS_DEFAULT];
   logic                slot_runnable [SLOTS_DEFAULT];
   logic [RAND_W-1:0]   lcg_state;
   logic [TICKET_W-1:0] min_t;
   logic [TICKET_W-1:0] max_t;
   logic [TICKET_W-1:0] dflt_t;
   rsp_type             results_due [$];

   initial begin
      error_count = 0;
      pending_count = 0;
      win_count = 0;
   end

   function automatic logic [TICKET_W-1:0] clamp_tickets(input logic signed [TICKET_W-1:0] ask);
      int ask_i;
      ask_i = ask;
      if (ask_i == 0) return dflt_t;
      if (ask_i < int'(min_t)) return min_t;
      if (ask_i > int'(max_t)) return max_t;
      return ask;
   endfunction

   function automatic logic [RAND_W-1:0] runnable_sum();
      logic [RAND_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < SLOTS_DEFAULT; i++)
         if (slot_runnable[i]) sum = sum + RAND_W'(slot_tickets[i]);
      return sum;
   endfunction

   function automatic logic [OUT_W-1:0] clip22(input logic [RAND_W-1:0] v);
      return (v > RAND_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
   endfunction

   task automatic predict_result(input req_type item, output rsp_type res);
      logic [RAND_W-1:0] sum;
      logic [RAND_W-1:0] next;
      logic [RAND_W-1:0] rem;
      logic              hit;
      res = '0;
      if (item.op == OP_UPDATE) begin
         res.stored_tickets = clamp_tickets(item.ticket_request);
         slot_tickets[item.slot] = res.stored_tickets;
         slot_runnable[item.slot] = item.runnable;
         res.total_tickets = clip22(runnable_sum());
      end else begin
         sum = runnable_sum();
         if (sum != '0) begin
            next = lcg_state * LCG_MUL + LCG_ADD;
            rem = next % sum;
            lcg_state = rem;
            res.draw_value = clip22(rem);
            res.total_tickets = clip22(sum);
            hit = 1'b0;
            for (int i = 0; i < SLOTS_DEFAULT; i++) begin
               if (!hit && slot_runnable[i]) begin
                  if (rem < RAND_W'(slot_tickets[i])) begin
                     hit = 1'b1;
                     res.found = 1'b1;
                     res.winner_slot = SLOT_W'(i);
                  end else begin
                     rem = rem - RAND_W'(slot_tickets[i]);
                  end
               end
            end
         end
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0d, got %0d", field, want, seen);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS_DEFAULT; i++) begin
            slot_tickets[i] = '0;
            slot_runnable[i] = 1'b0;
         end
         lcg_state = RAND_RESET;
         min_t = MIN_RESET;
         max_t = MAX_RESET;
         dflt_t = DEFAULT_RESET;
         results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MIN: min_t = csr_wdata;
               CSR_MAX: max_t = csr_wdata;
               CSR_DEFAULT: dflt_t = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_result(req_data, want);
            results_due.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $error("result arrived with no item outstanding: %p", rsp_data);
               error_count++;
            end else begin
               want = results_due.pop_front();
               if (want.found) win_count++;
               check_field("found", 32'(want.found), 32'(rsp_data.found));
               check_field("winner_slot", 32'(want.winner_slot), 32'(rsp_data.winner_slot));
               check_field("draw_value", 32'(want.draw_value), 32'(rsp_data.draw_value));
               check_field("total_tickets", 32'(want.total_tickets),
                           32'(rsp_data.total_tickets));
               check_field("stored_tickets", 32'(want.stored_tickets),
                           32'(rsp_data.stored_tickets));
            end
         end
      end
      pending_count = results_due.size();
   end

endmodule

/* tb/tb_lottery_scheduler_draw_core.sv */
`timescale 1ns / 100ps
// Testbench top for the lottery draw core: stimulus, flow control, watchdog and verdict.
module tb_lottery_scheduler_draw_core;
   import lsd_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 200;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count;
   int pending_count;
   int win_count;
   int idle_cycles = 0;
   int burst_left = 0;
   int n_update = 0;
   int n_draw = 0;
   int n_settings = 1;
   bit long_hold = 1'b0;
   logic [TICKET_W-1:0] cfg_lo = MIN_RESET;
   logic [TICKET_W-1:0] cfg_hi = MAX_RESET;

   always #2 clock = ~clock;

   lottery_scheduler_draw_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lottery_draw_checker u_draw_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .win_count     (win_count)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // result side: stall patterns of changing density, plus long holds on request
   initial begin : result_side
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(8, 64);
         end
         left--;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   function automatic req_type mk_update(input int slot, input int ask, input bit run);
      req_type it;
      it = '0;
      it.op = OP_UPDATE;
      it.slot = SLOT_W'(slot);
      it.ticket_request = TICKET_W'(ask);
      it.runnable = run;
      return it;
   endfunction

   function automatic req_type mk_draw();
      req_type it;
      it.op = OP_DRAW;
      it.slot = SLOT_W'($urandom);
      it.ticket_request = TICKET_W'($urandom);
      it.runnable = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic req_type rand_item(input int upd_pct);
      req_type it;
      if ($urandom_range(1, 100) > upd_pct) return mk_draw();
      it.op = OP_UPDATE;
      it.slot = SLOT_W'($urandom_range(0, SLOTS_DEFAULT - 1));
      it.runnable = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
         0: it.ticket_request = '0;
         1: it.ticket_request = TICKET_W'(-int'($urandom_range(1, 32768)));
         2: it.ticket_request = TICKET_W'(int'(cfg_lo) + int'($urandom_range(0, 2)) - 1);
         3: it.ticket_request = TICKET_W'(int'(cfg_hi) + int'($urandom_range(0, 2)) - 1);
         4: it.ticket_request = TICKET_W'($urandom);
         default: it.ticket_request = TICKET_W'($urandom_range(1, 300));
      endcase
      return it;
   endfunction

   // entered and left at a falling edge; valid stays up across a burst
   task automatic send_item(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      burst_left--;
      if (item.op == OP_UPDATE) n_update++;
      else n_draw++;
   endtask

   task automatic send_random(input int count, input int upd_pct);
      for (int k = 0; k < count; k++) send_item(rand_item(upd_pct));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MIN) cfg_lo = val;
      if (idx == CSR_MAX) cfg_hi = val;
   endtask

   task automatic set_limits(input logic [CSR_DATA_W-1:0] lo, input logic [CSR_DATA_W-1:0] hi,
                             input logic [CSR_DATA_W-1:0] dflt);
      drain();
      write_reg(CSR_MIN, lo);
      write_reg(CSR_MAX, hi);
      write_reg(CSR_DEFAULT, dflt);
      n_settings++;
   endtask

   initial begin : stimulus
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // reset limits: empty draw, each clamp branch, non-runnable slot
      send_item(mk_draw());
      send_item(mk_update(0, 0, 1'b1));
      send_item(mk_update(63, -32768, 1'b1));
      send_item(mk_update(31, 32767, 1'b1));
      send_item(mk_update(10, -1, 1'b1));
      send_item(mk_update(20, 1, 1'b0));
      send_item(mk_update(42, 100, 1'b1));
      send_item(mk_update(21, 101, 1'b1));
      repeat (5) send_item(mk_draw());
      send_item(mk_update(0, 55, 1'b0));
      send_item(mk_draw());
      send_random(280, 55);

      set_limits(16'd1, 16'd65535, 16'd65535);
      send_item(mk_update(1, 0, 1'b1));
      send_item(mk_update(2, 32767, 1'b1));
      send_item(mk_draw());
      long_hold = 1'b1;
      send_random(300, 60);

      // min above max
      set_limits(16'd65535, 16'd1, 16'd1);
      send_item(mk_update(5, 7, 1'b1));
      send_item(mk_update(6, 0, 1'b1));
      send_item(mk_draw());
      send_random(300, 70);

      // zero-ticket runnable slots
      set_limits(16'd0, 16'd5, 16'd0);
      send_item(mk_update(3, 0, 1'b1));
      send_item(mk_update(4, -7, 1'b1));
      send_item(mk_update(9, 3, 1'b1));
      repeat (3) send_item(mk_draw());
      send_random(150, 55);

      set_limits(16'd20, 16'd300, 16'd50);
      long_hold = 1'b1;
      send_random(420, 55);

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d items: %0d slot updates and %0d draws, %0d draws won by a slot.",
               n_update + n_draw, n_update, n_draw, win_count);
      $display("Ran %0d ticket limit settings, including min above max and zero-ticket slots.",
               n_settings);
      if (error_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         if (pending_count != 0) $display("%0d results never arrived", pending_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
